### rtl/epsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epsl_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 112;

    // configuration register indexes
    localparam logic [2:0] REG_SPEED_SCALE = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [2:0] REG_ERROR_BAND  = 3'd3;
    localparam logic [2:0] REG_DUTY_GAIN   = 3'd4;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd5;
    localparam logic [2:0] REG_PWM_MAX     = 3'd6;

    // direction codes
    localparam logic [1:0] DRV_OFF = 2'd0;
    localparam logic [1:0] DRV_FWD = 2'd1;
    localparam logic [1:0] DRV_REV = 2'd2;

    // 25600 is 100 percent in Q.8; divide by 2^10 then by 25 via reciprocal
    localparam logic [14:0] PCT_FULL_Q8 = 15'd25600;
    localparam logic [21:0] RECIP_25    = 22'd2684355;  // ceil(2^26 / 25)

    localparam int STEP_W = 4;

    // multiplier operand selects
    typedef enum logic [2:0] {
        A_NONE,
        A_DELTA,
        A_KPI,
        A_KP,
        A_HELD,
        A_MAG,
        A_QUOT
    } a_sel_t;

    typedef enum logic [2:0] {
        B_NONE,
        B_SCALE,
        B_ERR_NEW,
        B_ERR_OLD,
        B_DUTY_GAIN,
        B_PWM_MAX,
        B_RECIP
    } b_sel_t;

    // accumulator operations on the registered product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    // write-back actions
    typedef enum logic [2:0] {
        WB_NONE,
        WB_MEAS,
        WB_PI,
        WB_DUTY,
        WB_DIR_MAG,
        WB_QUOT,
        WB_OUT
    } wb_t;

    typedef enum logic {
        JMP_NONE,
        JMP_IF_STOP
    } jmp_t;

    typedef struct packed {
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        acc_op_t           acc_op;
        wb_t               wb;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } ctrl_word_t;

    // control program, one word per step
    function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '0;
        unique case (step)
            4'd0:
            begin
                cw.a_sel = A_DELTA;
                cw.b_sel = B_SCALE;
            end
            4'd1:
            begin
                cw.a_sel  = A_KPI;
                cw.b_sel  = B_ERR_NEW;
                cw.acc_op = ACC_LOAD;
            end
            4'd2:
            begin
                cw.a_sel  = A_KP;
                cw.b_sel  = B_ERR_OLD;
                cw.acc_op = ACC_LOAD;
                cw.wb     = WB_MEAS;
            end
            4'd3:
            begin
                cw.acc_op = ACC_SUB;
            end
            4'd4:
            begin
                cw.wb = WB_PI;
            end
            4'd5:
            begin
                cw.a_sel = A_HELD;
                cw.b_sel = B_DUTY_GAIN;
            end
            4'd6:
            begin
                cw.wb = WB_DUTY;
            end
            4'd7:
            begin
                cw.wb = WB_DIR_MAG;
            end
            4'd8:
            begin
                cw.a_sel  = A_MAG;
                cw.b_sel  = B_PWM_MAX;
                cw.jmp    = JMP_IF_STOP;
                cw.target = 4'd11;
            end
            4'd9:
            begin
                cw.wb = WB_QUOT;
            end
            4'd10:
            begin
                cw.a_sel = A_QUOT;
                cw.b_sel = B_RECIP;
            end
            4'd11:
            begin
                cw.wb   = WB_OUT;
                cw.last = 1'b1;
            end
            default:
            begin
                cw.wb   = WB_OUT;
                cw.last = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

### rtl/encoder_pi_speed_loop_top.sv
// the 12-step control program shares one registered 32x27 multiplier, so the
//   block works on one item at a time; stop skips the compare steps
// reset (rst_n low, asynchronous): control and config registers to defaults,
//   first tick pending; datapath registers have no reset
// input is taken only while the sequencer is idle; a finished result waits
//   in the output register while the next item is accepted
`timescale 1ns / 1ps
`default_nettype none

module encoder_pi_speed_loop_top
    import epsl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // encoder_count[15:0], setpoint[41:16]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // count_delta[15:0], measured_speed[41:16], control_value[73:42],
    // direction[75:74], pwm_forward[91:76], pwm_reverse[107:92]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [24:0]           cfg_wr_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration registers
    logic        [23:0] speed_scale_reg;
    logic signed [23:0] prop_gain_reg;
    logic signed [23:0] integ_gain_reg;
    logic        [24:0] error_band_reg;
    logic        [15:0] duty_gain_reg;
    logic        [14:0] dead_band_reg;
    logic        [15:0] pwm_max_reg;

    // sequencer and loop state
    logic                  state_reg,      state_next;
    logic [STEP_W-1:0]     step_reg,       step_next;
    logic [15:0]           last_count_reg, last_count_next;
    logic                  first_tick_reg, first_tick_next;
    logic signed [26:0]    err_older_reg,  err_older_next;
    logic signed [26:0]    err_newer_reg,  err_newer_next;
    logic signed [31:0]    accum_reg,      accum_next;
    logic signed [31:0]    held_reg,       held_next;
    logic                  out_valid_reg,  out_valid_next;

    // datapath registers
    logic signed [25:0]    sp_reg,         sp_next;
    logic signed [15:0]    delta_reg,      delta_next;
    logic signed [58:0]    prod_reg,       prod_next;
    logic signed [59:0]    acc_reg,        acc_next;
    logic signed [25:0]    meas_reg,       meas_next;
    logic signed [32:0]    duty_reg,       duty_next;
    logic [1:0]            dir_reg,        dir_next;
    logic [14:0]           mag_reg,        mag_next;
    logic [20:0]           quot_reg,       quot_next;
    logic [OUT_DATA_W-1:0] out_data_reg,   out_data_next;

    ctrl_word_t         cw;
    logic               in_accept;
    logic               advance;
    logic signed [24:0] kpi;
    logic signed [31:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [59:0] meas_rnd;
    logic signed [59:0] pi_sum;
    logic signed [31:0] pi_sat;
    logic signed [58:0] duty_rnd;
    logic signed [33:0] duty_ext;
    logic signed [33:0] duty_abs;
    logic signed [32:0] dead_pos;
    logic signed [26:0] err_abs;
    logic [15:0]        cmp_val;
    logic [15:0]        pwm_fwd;
    logic [15:0]        pwm_rev;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cw      = ucode_rom(step_reg);
    assign advance = (state_reg == ST_RUN) && !(cw.last && out_valid_reg && !m_axis_tready);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg <= 24'd158875;
            prop_gain_reg   <= 24'sd65536;
            integ_gain_reg  <= 24'sd18350;
            error_band_reg  <= 25'd0;
            duty_gain_reg   <= 16'd54613;
            dead_band_reg   <= 15'd3635;
            pwm_max_reg     <= 16'd3359;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SPEED_SCALE: speed_scale_reg <= cfg_wr_data[23:0];
                REG_PROP_GAIN:   prop_gain_reg   <= $signed(cfg_wr_data[23:0]);
                REG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_wr_data[23:0]);
                REG_ERROR_BAND:  error_band_reg  <= cfg_wr_data;
                REG_DUTY_GAIN:   duty_gain_reg   <= cfg_wr_data[15:0];
                REG_DEAD_BAND:   dead_band_reg   <= cfg_wr_data[14:0];
                REG_PWM_MAX:     pwm_max_reg     <= cfg_wr_data[15:0];
                default:         ;
            endcase
        end
    end

    // shared multiplier operands
    assign kpi = 25'(prop_gain_reg) + 25'(integ_gain_reg);

    always_comb
    begin
        case (cw.a_sel)
            A_DELTA: mul_a = 32'(delta_reg);
            A_KPI:   mul_a = 32'(kpi);
            A_KP:    mul_a = 32'(prop_gain_reg);
            A_HELD:  mul_a = held_reg;
            A_MAG:   mul_a = $signed({17'd0, mag_reg});
            A_QUOT:  mul_a = $signed({11'd0, quot_reg});
            default: mul_a = 32'sd0;
        endcase
        case (cw.b_sel)
            B_SCALE:     mul_b = $signed({3'd0, speed_scale_reg});
            B_ERR_NEW:   mul_b = err_newer_reg;
            B_ERR_OLD:   mul_b = err_older_reg;
            B_DUTY_GAIN: mul_b = $signed({11'd0, duty_gain_reg});
            B_PWM_MAX:   mul_b = $signed({11'd0, pwm_max_reg});
            B_RECIP:     mul_b = $signed({5'd0, RECIP_25});
            default:     mul_b = 27'sd0;
        endcase
    end

    // write-back arithmetic
    assign meas_rnd = (acc_reg + 60'sd128) >>> 8;
    assign pi_sum   = ((acc_reg + 60'sd32768) >>> 16) + 60'(accum_reg);
    assign duty_rnd = (prod_reg + 59'sd32768) >>> 16;
    assign duty_ext = 34'(duty_reg);
    assign duty_abs = (duty_ext < 34'sd0) ? -duty_ext : duty_ext;
    assign dead_pos = $signed({18'd0, dead_band_reg});
    assign err_abs  = (err_newer_reg < 27'sd0) ? -err_newer_reg : err_newer_reg;
    assign cmp_val  = prod_reg[41:26];

    always_comb
    begin
        if (pi_sum > 60'sd2147483647)
            pi_sat = 32'sh7FFFFFFF;
        else if (pi_sum < -60'sd2147483648)
            pi_sat = 32'sh80000000;
        else
            pi_sat = 32'(pi_sum);
    end

    assign pwm_fwd = (dir_reg == DRV_FWD) ? cmp_val : 16'd0;
    assign pwm_rev = (dir_reg == DRV_REV) ? cmp_val : 16'd0;

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        last_count_next = last_count_reg;
        first_tick_next = first_tick_reg;
        err_older_next  = err_older_reg;
        err_newer_next  = err_newer_reg;
        accum_next      = accum_reg;
        held_next       = held_reg;
        out_valid_next  = out_valid_reg;
        sp_next         = sp_reg;
        delta_next      = delta_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        meas_next       = meas_reg;
        duty_next       = duty_reg;
        dir_next        = dir_reg;
        mag_next        = mag_reg;
        quot_next       = quot_reg;
        out_data_next   = out_data_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        // take a new item: count difference and first tick seeding
        if (in_accept)
        begin
            delta_next      = $signed(s_axis_tdata[15:0] - last_count_reg);
            last_count_next = s_axis_tdata[15:0];
            sp_next         = $signed(s_axis_tdata[41:16]);
            if (first_tick_reg)
            begin
                err_older_next  = 27'($signed(s_axis_tdata[41:16]));
                err_newer_next  = 27'($signed(s_axis_tdata[41:16]));
                accum_next      = 32'sd0;
                first_tick_next = 1'b0;
            end
            step_next  = '0;
            state_next = ST_RUN;
        end

        if (advance)
        begin
            prod_next = mul_a * mul_b;

            case (cw.acc_op)
                ACC_LOAD: acc_next = 60'(prod_reg);
                ACC_SUB:  acc_next = acc_reg - 60'(prod_reg);
                default:  ;
            endcase

            case (cw.wb)
                WB_MEAS:
                begin
                    if (meas_rnd > 60'sd33554431)
                        meas_next = 26'sh1FFFFFF;
                    else if (meas_rnd < -60'sd33554432)
                        meas_next = 26'sh2000000;
                    else
                        meas_next = 26'(meas_rnd);
                end
                WB_PI:
                begin
                    accum_next = pi_sat;
                    if ({1'b0, err_abs[25:0]} >= {2'b0, error_band_reg} || err_abs[26])
                        held_next = pi_sat;
                    err_older_next = err_newer_reg;
                    err_newer_next = 27'(sp_reg) - 27'(meas_reg);
                end
                WB_DUTY:
                begin
                    duty_next = 33'(duty_rnd);
                end
                WB_DIR_MAG:
                begin
                    if (duty_reg > dead_pos)
                        dir_next = DRV_FWD;
                    else if (duty_reg < -dead_pos)
                        dir_next = DRV_REV;
                    else
                        dir_next = DRV_OFF;
                    if (duty_abs > 34'(PCT_FULL_Q8))
                        mag_next = PCT_FULL_Q8;
                    else
                        mag_next = duty_abs[14:0];
                end
                WB_QUOT:
                begin
                    quot_next = prod_reg[30:10];
                end
                WB_OUT:
                begin
                    out_data_next  = {4'd0, pwm_rev, pwm_fwd, dir_reg, held_reg,
                                      meas_reg, delta_reg};
                    out_valid_next = 1'b1;
                end
                default: ;
            endcase

            // step counter with conditional skip of the compare math
            if (cw.last)
                state_next = ST_IDLE;
            else if (cw.jmp == JMP_IF_STOP && dir_reg == DRV_OFF)
                step_next = cw.target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            last_count_reg <= 16'd0;
            first_tick_reg <= 1'b1;
            err_older_reg  <= 27'sd0;
            err_newer_reg  <= 27'sd0;
            accum_reg      <= 32'sd0;
            held_reg       <= 32'sd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            last_count_reg <= last_count_next;
            first_tick_reg <= first_tick_next;
            err_older_reg  <= err_older_next;
            err_newer_reg  <= err_newer_next;
            accum_reg      <= accum_next;
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sp_reg       <= sp_next;
        delta_reg    <= delta_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        meas_reg     <= meas_next;
        duty_reg     <= duty_next;
        dir_reg      <= dir_next;
        mag_reg      <= mag_next;
        quot_reg     <= quot_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### rtl/epsl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module epsl_checker
    import epsl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while an item is in work");

    // never both pwm channels active
    a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[91:76] == 16'd0 || m_axis_tdata[107:92] == 16'd0))
        else $error("both pwm channels driven");

    // stopped motor drives no channel
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[75:74] == DRV_OFF
            |-> m_axis_tdata[107:76] == 32'd0)
        else $error("pwm output while stopped");

endmodule

bind encoder_pi_speed_loop_top epsl_checker u_epsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/tb_encoder_pi_speed_loop_top.sv
`timescale 1ns / 1ps

module tb_encoder_pi_speed_loop_top;
    import epsl_pkg::*;

    // config index with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam longint SPEED_MAX = 64'sd33554431;
    localparam longint SPEED_MIN = -64'sd33554432;
    localparam longint ACC_MAX   = 64'sd2147483647;
    localparam longint ACC_MIN   = -64'sd2147483648;
    localparam logic signed [25:0] SP_MAX = 26'sh1FFFFFF;
    localparam logic signed [25:0] SP_MIN = -26'sh2000000;

    // one tick result, count_delta in the lowest bits
    typedef struct packed {
        logic [15:0]        pwm_reverse;
        logic [15:0]        pwm_forward;
        logic [1:0]         direction;
        logic signed [31:0] control_value;
        logic signed [25:0] measured_speed;
        logic signed [15:0] count_delta;
    } tick_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // encoder_count[15:0], setpoint[41:16]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // count_delta[15:0], measured_speed[41:16], control_value[73:42],
    // direction[75:74], pwm_forward[91:76], pwm_reverse[107:92]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en     = 1'b0;
    logic [2:0]            cfg_addr      = '0;
    logic [24:0]           cfg_wr_data   = '0;

    encoder_pi_speed_loop_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #6 clk = ~clk;

    // register copies, reset values
    logic [23:0]        speed_scale = 24'd158875;
    logic signed [23:0] prop_gain   = 24'sd65536;
    logic signed [23:0] integ_gain  = 24'sd18350;
    logic [24:0]        error_band  = 25'd0;
    logic [15:0]        duty_gain   = 16'd54613;
    logic [14:0]        dead_band   = 15'd3635;
    logic [15:0]        pwm_max     = 16'd3359;

    // loop state
    logic [15:0]        last_count   = 16'd0;
    bit                 first_tick   = 1'b1;
    logic signed [31:0] error_older  = '0;
    logic signed [31:0] error_newer  = '0;
    logic signed [31:0] accum_output = '0;
    logic signed [31:0] held_command = '0;

    logic [IN_DATA_W-1:0] pending_ticks[$];
    tick_result_t         expected_ticks[$];

    int  items_offered = 0;
    int  items_taken   = 0;
    int  results_seen  = 0;
    int  results_noted = 0;
    int  send_wait     = 0;
    int  recv_wait     = 0;
    bit  gaps_on       = 1'b1;
    int  fail_count    = 0;
    int  settings_used = 1;
    int  dir_count[4]  = '{0, 0, 0, 0};

    // random profile state
    logic [15:0]        enc_pos = '0;
    int                 enc_rate = 0;
    logic signed [25:0] run_sp = '0;

    // one control tick of the speed loop
    function automatic tick_result_t compute_tick_outputs(input logic [15:0] cnt,
                                                          input logic signed [25:0] sp);
        tick_result_t r;
        logic [15:0]  diff;
        longint       delta, meas, u, aerr, duty, mag, cmp;
        logic [1:0]   dir;
        diff = cnt - last_count;
        delta = longint'($signed(diff));
        last_count = cnt;
        meas = (delta * longint'(speed_scale) + 128) >>> 8;
        if (meas > SPEED_MAX)
            meas = SPEED_MAX;
        else if (meas < SPEED_MIN)
            meas = SPEED_MIN;

        // first tick seeds both errors with the setpoint
        if (first_tick)
        begin
            error_older  = sp;
            error_newer  = sp;
            accum_output = '0;
            first_tick   = 1'b0;
        end

        // velocity-form pi step
        u = (longint'(prop_gain) + longint'(integ_gain)) * longint'(error_newer)
            - longint'(prop_gain) * longint'(error_older);
        u = ((u + 32768) >>> 16) + longint'(accum_output);
        if (u > ACC_MAX)
            u = ACC_MAX;
        else if (u < ACC_MIN)
            u = ACC_MIN;
        accum_output = u[31:0];
        aerr = (error_newer < 0) ? -longint'(error_newer) : longint'(error_newer);
        if (aerr >= longint'(error_band))
            held_command = accum_output;
        error_older = error_newer;
        error_newer = 32'(longint'(sp) - meas);

        // duty, direction and compare
        duty = (longint'(held_command) * longint'(duty_gain) + 32768) >>> 16;
        if (duty > longint'(dead_band))
            dir = DRV_FWD;
        else if (duty < -longint'(dead_band))
            dir = DRV_REV;
        else
            dir = DRV_OFF;
        mag = (duty < 0) ? -duty : duty;
        cmp = mag * longint'(pwm_max) / longint'(PCT_FULL_Q8);
        if (cmp > longint'(pwm_max))
            cmp = longint'(pwm_max);

        r.count_delta    = diff;
        r.measured_speed = meas[25:0];
        r.control_value  = held_command;
        r.direction      = dir;
        r.pwm_forward    = (dir == DRV_FWD) ? cmp[15:0] : 16'd0;
        r.pwm_reverse    = (dir == DRV_REV) ? cmp[15:0] : 16'd0;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // input driver, items change at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && items_taken != items_offered))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                s_axis_tdata  <= pending_ticks.pop_front();
                s_axis_tvalid <= 1'b1;
                items_offered++;
                send_wait = gaps_on ? $urandom_range(0, 17) : 0;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result stall, drawn once per result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_seen != results_noted)
            begin
                results_noted = results_seen;
                recv_wait = gaps_on ? $urandom_range(0, 17) : 0;
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted input, check on accepted result
    always @(posedge clk)
    begin
        tick_result_t got;
        tick_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                items_taken++;
                expected_ticks.push_back(compute_tick_outputs(s_axis_tdata[15:0],
                                                              s_axis_tdata[41:16]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got = tick_result_t'(m_axis_tdata[107:0]);
                if (expected_ticks.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    dir_count[want.direction]++;
                    check_field("count_delta", want.count_delta, got.count_delta);
                    check_field("measured_speed", want.measured_speed, got.measured_speed);
                    check_field("control_value", want.control_value, got.control_value);
                    check_field("direction", want.direction, got.direction);
                    check_field("pwm_forward", want.pwm_forward, got.pwm_forward);
                    check_field("pwm_reverse", want.pwm_reverse, got.pwm_reverse);
                end
            end
        end
    end

    task automatic push_tick(input logic [15:0] cnt, input logic signed [25:0] sp);
        pending_ticks.push_back({6'd0, sp, cnt});
    endtask

    // wait until every item is in and every result is out
    task automatic drain();
        while (pending_ticks.size() != 0 || items_taken != items_offered
               || expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_SPEED_SCALE: speed_scale = val[23:0];
            REG_PROP_GAIN:   prop_gain   = val[23:0];
            REG_INTEG_GAIN:  integ_gain  = val[23:0];
            REG_ERROR_BAND:  error_band  = val;
            REG_DUTY_GAIN:   duty_gain   = val[15:0];
            REG_DEAD_BAND:   dead_band   = val[14:0];
            REG_PWM_MAX:     pwm_max     = val[15:0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // signed gain, either moderate or anywhere in range
    function automatic logic [24:0] random_gain();
        int span;
        span = ($urandom_range(0, 2) == 0) ? 8388607 : 150000;
        return {1'b0, 24'(int'($urandom_range(0, 2 * span)) - span)};
    endfunction

    task automatic random_settings(input bit zero_pwm);
        write_reg(REG_SPEED_SCALE, ($urandom_range(0, 3) == 0) ?
                  25'($urandom_range(0, 24'hFFFFFF)) : 25'($urandom_range(0, 400000)));
        write_reg(REG_PROP_GAIN, random_gain());
        write_reg(REG_INTEG_GAIN, random_gain());
        write_reg(REG_ERROR_BAND, ($urandom_range(0, 4) == 0) ?
                  25'($urandom_range(0, 25'h1FFFFFF)) : 25'($urandom_range(0, 4000)));
        write_reg(REG_DUTY_GAIN, 25'($urandom_range(0, 65535)));
        write_reg(REG_DEAD_BAND, 25'($urandom_range(0, 25600)));
        write_reg(REG_PWM_MAX, zero_pwm ? 25'd0 : 25'($urandom_range(1, 65535)));
        settings_used++;
    endtask

    // mostly steady encoder motion toward a setpoint, some corner and noise items
    function automatic logic [IN_DATA_W-1:0] random_tick();
        int                 pick;
        logic [15:0]        cnt;
        logic signed [25:0] sp;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            enc_rate = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                   : int'($urandom_range(0, 6000)) - 3000;
            run_sp = ($urandom_range(0, 3) == 0) ? 26'($urandom())
                     : 26'(enc_rate * 620 + int'($urandom_range(0, 2000)) - 1000);
        end
        if (pick < 80)
        begin
            cnt = enc_pos + 16'(enc_rate + int'($urandom_range(0, 16)) - 8);
            sp  = run_sp;
        end
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0: cnt = 16'h0000;
                1: cnt = 16'hFFFF;
                2: cnt = enc_pos + 16'h8000;
                default: cnt = enc_pos + 16'h7FFF;
            endcase
            case ($urandom_range(0, 3))
                0: sp = SP_MAX;
                1: sp = SP_MIN;
                2: sp = '0;
                default: sp = -26'sd1;
            endcase
        end
        else
        begin
            cnt = 16'($urandom());
            sp  = 26'($urandom());
        end
        enc_pos = cnt;
        return {6'd0, sp, cnt};
    endfunction

    task automatic run_phase(input int n, input bit gaps);
        @(posedge clk);
        gaps_on = gaps;
        repeat (n)
            pending_ticks.push_back(random_tick());
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: first tick from zero, forward and reverse drive, wraps, extremes
        @(posedge clk);
        push_tick(16'h0000, '0);
        repeat (4)
            push_tick(16'h0000, 26'sd25600);
        repeat (5)
            push_tick(16'h0000, -26'sd25600);
        push_tick(16'hFFFF, SP_MAX);
        push_tick(16'h7FFF, SP_MIN);
        push_tick(16'hFFFF, '0);
        push_tick(16'h7FFE, -26'sd1);
        push_tick(16'hFFFD, 26'sd12800);
        push_tick(16'hFFFD, '0);
        push_tick(16'h0001, SP_MAX);
        push_tick(16'h8001, SP_MIN);
        push_tick(16'h5555, 26'h2AAAAAA);
        push_tick(16'hAAAA, 26'h1555555);
        push_tick(16'h0000, '0);
        drain();

        // default settings, no idling on either side
        run_phase(150, 1'b0);

        // extremes: largest scale, gains at their signed extremes, band high, no deadband
        write_reg(REG_SPEED_SCALE, 25'hFFFFFF);
        write_reg(REG_PROP_GAIN, 25'h7FFFFF);
        write_reg(REG_INTEG_GAIN, 25'h800000);
        write_reg(REG_ERROR_BAND, 25'h1FFFFFF);
        write_reg(REG_DUTY_GAIN, 25'hFFFF);
        write_reg(REG_DEAD_BAND, 25'd0);
        write_reg(REG_PWM_MAX, 25'hFFFF);
        write_reg(REG_UNUSED, 25'h1ABCDEF);
        settings_used++;
        run_phase(120, 1'b1);

        // opposite extremes: zero scale and duty, deadband of 25600, compare limit of one
        write_reg(REG_SPEED_SCALE, 25'd0);
        write_reg(REG_PROP_GAIN, 25'h800000);
        write_reg(REG_INTEG_GAIN, 25'h7FFFFF);
        write_reg(REG_ERROR_BAND, 25'd0);
        write_reg(REG_DUTY_GAIN, 25'd0);
        write_reg(REG_DEAD_BAND, 25'd25600);
        write_reg(REG_PWM_MAX, 25'd1);
        settings_used++;
        run_phase(120, 1'b1);

        // compare limit of zero
        random_settings(1'b1);
        run_phase(120, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            random_settings(1'b0);
            run_phase(130, p[0]);
        end

        // back to reset values
        write_reg(REG_SPEED_SCALE, 25'd158875);
        write_reg(REG_PROP_GAIN, 25'd65536);
        write_reg(REG_INTEG_GAIN, 25'd18350);
        write_reg(REG_ERROR_BAND, 25'd0);
        write_reg(REG_DUTY_GAIN, 25'd54613);
        write_reg(REG_DEAD_BAND, 25'd3635);
        write_reg(REG_PWM_MAX, 25'd3359);
        settings_used++;
        run_phase(100, 1'b1);

        repeat (20) @(posedge clk);
        $display("Checked %0d ticks across %0d register settings", results_seen, settings_used);
        $display("Drive seen: %0d stop, %0d forward, %0d reverse",
                 dir_count[DRV_OFF], dir_count[DRV_FWD], dir_count[DRV_REV]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(4_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
